// File: rtl/core/pppt_pkg.sv
// Shared constants and types for the Pauli product phase tracker.
package pppt_pkg;

  localparam int WORD_W   = 64;                  // width of one bit-plane word
  localparam int LANE_BITS = 64;                 // active qubit lanes per word (1..64)
  localparam int PHASE_W  = 2;                   // power of i, mod 4
  localparam int GROUP_W  = 8;                   // lanes per first-level reduction group
  localparam int NGROUP   = (LANE_BITS + GROUP_W - 1) / GROUP_W;
  localparam int PAD_W    = NGROUP * GROUP_W;

  typedef logic [PHASE_W-1:0] phase_t;

  // side information that follows a word down the pipeline
  typedef struct packed {
    logic final_word;
    logic left_negative;
    logic right_negative;
  } ctl_t;

endpackage

// File: rtl/core/pppt_lane.sv
// One qubit lane: product bits and the two-bit mod-4 phase counter.
module pppt_lane import pppt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic final_word,
  input  logic x_left,
  input  logic z_left,
  input  logic x_right,
  input  logic z_right,
  output logic x_product,
  output logic z_product,
  output logic low_next,
  output logic high_next
);

  logic low;
  logic high;
  logic xlzr;
  logic anti;

  assign x_product = x_left ^ x_right;
  assign z_product = z_left ^ z_right;
  assign xlzr      = x_left & z_right;
  assign anti      = (x_right & z_left) ^ xlzr;
  // carry into bit 1 uses the old low bit and the sign of this lane's contribution
  assign high_next = high ^ ((low ^ x_product ^ z_product ^ xlzr) & anti);
  assign low_next  = low ^ anti;

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= 1'b0;
      high <= 1'b0;
    end else if (accept) begin
      if (final_word) begin
        low  <= 1'b0;
        high <= 1'b0;
      end else begin
        low  <= low_next;
        high <= high_next;
      end
    end
  end

endmodule

// File: rtl/core/pppt_merge.sv
// Merges the lane counters: registered per-group sums, then the final mod-4 total.
module pppt_merge import pppt_pkg::*; (
  input  logic                 clk,
  input  logic                 load,
  input  logic [LANE_BITS-1:0] low_in,
  input  logic [LANE_BITS-1:0] high_in,
  input  ctl_t                 ctl_in,
  output ctl_t                 ctl,
  output phase_t               phase_power
);

  logic [PAD_W-1:0] low_pad;
  logic [PAD_W-1:0] high_pad;
  phase_t           gsum_c [NGROUP];
  logic             ghi_c  [NGROUP];
  phase_t           gsum   [NGROUP];
  logic             ghi    [NGROUP];

  assign low_pad  = PAD_W'(low_in);
  assign high_pad = PAD_W'(high_in);

  // low bits weigh 1, high bits weigh 2: only their parity matters mod 4
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      gsum_c[g] = '0;
      ghi_c[g]  = 1'b0;
      for (int b = 0; b < GROUP_W; b++) begin
        gsum_c[g] = gsum_c[g] + PHASE_W'(low_pad[g*GROUP_W + b]);
        ghi_c[g]  = ghi_c[g] ^ high_pad[g*GROUP_W + b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gsum <= gsum_c;
      ghi  <= ghi_c;
      ctl  <= ctl_in;
    end
  end

  always_comb begin
    phase_t tot;
    logic   par;
    tot = '0;
    par = ctl.right_negative;
    for (int g = 0; g < NGROUP; g++) begin
      tot = tot + gsum[g];
      par = par ^ ghi[g];
    end
    phase_power = ctl.final_word ? phase_t'(tot + {par, 1'b0}) : '0;
  end

endmodule

// File: rtl/core/pauli_product_phase_tracker_core.sv
// Top level of the Pauli product phase tracker.
// Multiplies two Pauli strings one 64-bit word of X/Z bit planes per transfer.
// Input channel (in_valid/in_ready): x_left, z_left, x_right, z_right, the two
// signs and final_word. Output channel (out_valid/out_ready): product words,
// phase_power, product_negative, anticommute_flag and final_out.
// Each input transfer gives exactly one output transfer, in order. The product
// words are the XOR of the operands. Every lane keeps a two-bit phase counter;
// on the final word the counters (this word included) are summed mod 4 with the
// right sign, and then cleared. Phase fields are zero on other words.
// Pipeline: lane stage, group reduction stage, output register. Throughput: one
// word per cycle while the receiver does not stall.
// Each stage holds its own valid bit, so while the receiver stalls the input
// keeps being taken until all three stages are full; in_ready then drops.
// Reset (rst, synchronous) empties the pipeline and clears all lane counters.
module pauli_product_phase_tracker_core import pppt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] x_left,
  input  logic [WORD_W-1:0] z_left,
  input  logic [WORD_W-1:0] x_right,
  input  logic [WORD_W-1:0] z_right,
  input  logic              left_negative,
  input  logic              right_negative,
  input  logic              final_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] x_product,
  output logic [WORD_W-1:0] z_product,
  output phase_t            phase_power,
  output logic              product_negative,
  output logic              anticommute_flag,
  output logic              final_out
);

  logic                 accept;
  logic                 ld2;
  logic                 ld3;
  logic                 v1;
  logic                 v2;
  logic [WORD_W-1:0]    xp_c;
  logic [WORD_W-1:0]    zp_c;
  logic [LANE_BITS-1:0] low_c;
  logic [LANE_BITS-1:0] high_c;
  logic [WORD_W-1:0]    xp1;
  logic [WORD_W-1:0]    zp1;
  logic [LANE_BITS-1:0] low1;
  logic [LANE_BITS-1:0] high1;
  ctl_t                 ctl1;
  ctl_t                 ctl2;
  logic [WORD_W-1:0]    xp2;
  logic [WORD_W-1:0]    zp2;
  phase_t               power2;

  assign ld3      = v2 && (!out_valid || out_ready);
  assign ld2      = v1 && (!v2 || ld3);
  assign in_ready = !v1 || ld2;
  assign accept   = in_valid && in_ready;

  for (genvar i = 0; i < WORD_W; i++) begin : g_lane
    if (i < LANE_BITS) begin : g_on
      pppt_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .accept     (accept),
        .final_word (final_word),
        .x_left     (x_left[i]),
        .z_left     (z_left[i]),
        .x_right    (x_right[i]),
        .z_right    (z_right[i]),
        .x_product  (xp_c[i]),
        .z_product  (zp_c[i]),
        .low_next   (low_c[i]),
        .high_next  (high_c[i])
      );
    end else begin : g_off
      assign xp_c[i] = 1'b0;
      assign zp_c[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept)   v1 <= 1'b1;
      else if (ld2) v1 <= 1'b0;
      if (ld2)      v2 <= 1'b1;
      else if (ld3) v2 <= 1'b0;
      if (ld3)                out_valid <= 1'b1;
      else if (out_ready)     out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xp1   <= xp_c;
      zp1   <= zp_c;
      low1  <= low_c;
      high1 <= high_c;
      ctl1  <= '{final_word: final_word, left_negative: left_negative,
                 right_negative: right_negative};
    end
    if (ld2) begin
      xp2 <= xp1;
      zp2 <= zp1;
    end
    if (ld3) begin
      x_product        <= xp2;
      z_product        <= zp2;
      phase_power      <= power2;
      product_negative <= ctl2.final_word && (ctl2.left_negative ^ power2[1]);
      anticommute_flag <= power2[0];
      final_out        <= ctl2.final_word;
    end
  end

  pppt_merge u_merge (
    .clk         (clk),
    .load        (ld2),
    .low_in      (low1),
    .high_in     (high1),
    .ctl_in      (ctl1),
    .ctl         (ctl2),
    .phase_power (power2)
  );

endmodule

// File: rtl/core/pppt_checker.sv
// Port-level checks for the Pauli product phase tracker, bound to the top level.
module pppt_checker import pppt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] x_product,
  input logic [WORD_W-1:0] z_product,
  input phase_t            phase_power,
  input logic              product_negative,
  input logic              anticommute_flag,
  input logic              final_out
);

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_product) && $stable(z_product)
      && $stable(phase_power) && $stable(final_out))
    else $error("result changed while stalled");

  // phase fields only on the final word
  a_phase_gate: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_out |-> phase_power == '0 && !product_negative && !anticommute_flag)
    else $error("phase reported on a non-final word");

  a_anti_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> anticommute_flag == phase_power[0])
    else $error("anticommute flag disagrees with phase");

  // three-stage pipeline: out_valid cannot rise after reset until a word has passed the lane and group reduction stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid)
    else $error("output valid too soon after reset");

endmodule

bind pauli_product_phase_tracker_core pppt_checker u_pppt_checker (.*);
